[design/byte_sequence_text_encoder_unit_defines.svh]
// assertion macros for the byte sequence text encoder
// no dependencies; clk and rst are taken from the including module
`ifndef BYTE_SEQUENCE_TEXT_ENCODER_UNIT_DEFINES_SVH
`define BYTE_SEQUENCE_TEXT_ENCODER_UNIT_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define BSTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bste check failed");

// antecedent holds, consequent in the next cycle
`define BSTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bste check failed");

`endif

[design/bste_pkg.sv]
// shared types, character constants and encoding helpers
// for the byte sequence text encoder; no dependencies
package bste_pkg;

  // encoding modes
  typedef enum logic [2:0] {
    MODE_B64    = 3'd0,
    MODE_QHEX   = 3'd1,
    MODE_HEX    = 3'd2,
    MODE_BIN    = 3'd3,
    MODE_BITDOT = 3'd4
  } mode_t;

  // register index of encode_mode
  localparam logic CFG_IDX_ENCODE_MODE = 1'b0;

  localparam int unsigned MAX_CHARS = 12;
  localparam int unsigned TEXT_W    = 8 * MAX_CHARS;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'b0, nib};
    end
    return 8'h57 + {4'b0, nib};
  endfunction

  // base64 alphabet lookup
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    priority if (idx < 6'd26) begin
      return 8'h41 + wide;
    end else if (idx < 6'd52) begin
      return 8'h47 + wide;
    end else if (idx < 6'd62) begin
      return wide - 8'd4;
    end else if (idx == 6'd62) begin
      return CH_PLUS;
    end else begin
      return CH_SLASH;
    end
  endfunction

  // four characters for a group of n bytes (1 to 3), padded with '='
  function automatic logic [31:0] b64_group(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [1:0] n);
    logic [7:0] c2;
    logic [7:0] c3;
    c2 = (n >= 2'd2) ? b64_char({b1[3:0], b2[7:6]}) : CH_EQUAL;
    c3 = (n == 2'd3) ? b64_char(b2[5:0]) : CH_EQUAL;
    return {b64_char(b0[7:2]), b64_char({b0[1:0], b1[7:4]}), c2, c3};
  endfunction

endpackage

[design/byte_sequence_text_encoder_unit.sv]
// top level of the byte sequence text encoder
// depends on bste_pkg and byte_sequence_text_encoder_unit_defines.svh
`include "byte_sequence_text_encoder_unit_defines.svh"

// Encodes a byte stream, one byte per input transfer, into ASCII text, one
// character per output transfer, in base64 ("b64" prefix), quoted hex, "bx"
// hex, "bb" binary or binary with nibble dots, as chosen by encode_mode
// (address 0; codes 5 to 7 act as base64). All characters of an input
// transfer (0 to 12) are formed at once into a result buffer; that buffer
// then shifts them out one per cycle while out_ready is high. A byte yields
// ten characters in binary-dot mode (nine for the last byte), eight in
// binary and two in hex; in base64 two of every three bytes yield nothing
// but are still taken as input transfers.
// The next item is taken in the cycle the last character of the previous one
// leaves. run_last marks an item's last character, sequence_end that of an item
// ending the sequence. Change encode_mode only while no text is pending.
module byte_sequence_text_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_sequence,
  // output characters
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        run_last,
  output logic        sequence_end
);
  import bste_pkg::*;

  logic [2:0]        encode_mode;
  mode_t             mode_eff;

  logic              at_start;
  logic [15:0]       pending_bytes;
  logic [1:0]        pending_count;

  logic [TEXT_W-1:0] buf_chars;
  logic [3:0]        buf_left;
  logic              buf_ends;

  logic              in_xfer;
  logic              out_xfer;
  logic              ends;

  logic [23:0]       pre_word;
  logic [1:0]        pre_len;
  logic [TEXT_W-1:0] body;
  logic [3:0]        body_len;
  logic [TEXT_W-1:0] text;
  logic [3:0]        text_len;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_ENCODE_MODE) ? {29'b0, encode_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode <= MODE_B64;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_ENCODE_MODE) begin
      encode_mode <= pwdata[2:0];
    end
  end

  // unused codes fall back to base64
  always_comb begin
    unique case (encode_mode)
      MODE_QHEX, MODE_HEX, MODE_BIN, MODE_BITDOT: mode_eff = mode_t'(encode_mode);
      default:                                    mode_eff = MODE_B64;
    endcase
  end

  // handshakes
  assign out_valid    = (buf_left != 4'd0);
  assign in_ready     = !out_valid || (out_ready && buf_left == 4'd1);
  assign in_xfer      = in_valid && in_ready;
  assign out_xfer     = out_valid && out_ready;
  assign ends         = empty_sequence || last_byte;

  assign out_char     = buf_chars[TEXT_W-1 -: 8];
  assign run_last     = (buf_left == 4'd1);
  assign sequence_end = run_last && buf_ends;

  // prefix on the first item of a sequence
  always_comb begin
    pre_word = 24'b0;
    pre_len  = 2'd0;
    if (at_start) begin
      unique case (mode_eff)
        MODE_QHEX: begin
          pre_word = {CH_QUOTE, 16'b0};
          pre_len  = 2'd1;
        end
        MODE_HEX: begin
          pre_word = {CH_LC_B, CH_LC_X, 8'b0};
          pre_len  = 2'd2;
        end
        MODE_BIN, MODE_BITDOT: begin
          pre_word = {CH_LC_B, CH_LC_B, 8'b0};
          pre_len  = 2'd2;
        end
        default: begin
          pre_word = {CH_LC_B, CH_SIX, CH_FOUR};
          pre_len  = 2'd3;
        end
      endcase
    end
  end

  // body characters, left aligned
  always_comb begin
    body     = '0;
    body_len = 4'd0;
    if (empty_sequence) begin
      // close the sequence
      if (mode_eff == MODE_B64 && pending_count == 2'd1) begin
        body[TEXT_W-1 -: 32] = b64_group(pending_bytes[15:8], 8'd0, 8'd0, 2'd1);
        body_len             = 4'd4;
      end else if (mode_eff == MODE_B64 && pending_count == 2'd2) begin
        body[TEXT_W-1 -: 32] = b64_group(pending_bytes[15:8], pending_bytes[7:0],
                                         8'd0, 2'd2);
        body_len             = 4'd4;
      end else if (mode_eff == MODE_QHEX) begin
        body[TEXT_W-1 -: 8] = CH_QUOTE;
        body_len            = 4'd1;
      end
    end else begin
      unique case (mode_eff)
        MODE_QHEX, MODE_HEX: begin
          body[TEXT_W-1 -: 16] = {hex_char(data_byte[7:4]), hex_char(data_byte[3:0])};
          body_len             = 4'd2;
          if (mode_eff == MODE_QHEX && last_byte) begin
            body[TEXT_W-17 -: 8] = CH_QUOTE;
            body_len             = 4'd3;
          end
        end
        MODE_BIN: begin
          for (int i = 0; i < 8; i++) begin
            body[TEXT_W-1-8*i -: 8] = data_byte[7-i] ? CH_ONE : CH_ZERO;
          end
          body_len = 4'd8;
        end
        MODE_BITDOT: begin
          for (int i = 0; i < 4; i++) begin
            body[TEXT_W-1-8*i -: 8]      = data_byte[7-i] ? CH_ONE : CH_ZERO;
            body[TEXT_W-1-8*(i+5) -: 8] = data_byte[3-i] ? CH_ONE : CH_ZERO;
          end
          body[TEXT_W-1-8*4 -: 8] = CH_DOT;
          body_len                = 4'd9;
          if (!last_byte) begin
            body[TEXT_W-1-8*9 -: 8] = CH_DOT;
            body_len                = 4'd10;
          end
        end
        default: begin
          priority if (pending_count == 2'd2) begin
            body[TEXT_W-1 -: 32] = b64_group(pending_bytes[15:8], pending_bytes[7:0],
                                             data_byte, 2'd3);
            body_len             = 4'd4;
          end else if (last_byte && pending_count == 2'd0) begin
            body[TEXT_W-1 -: 32] = b64_group(data_byte, 8'd0, 8'd0, 2'd1);
            body_len             = 4'd4;
          end else if (last_byte) begin
            body[TEXT_W-1 -: 32] = b64_group(pending_bytes[15:8], data_byte, 8'd0, 2'd2);
            body_len             = 4'd4;
          end else begin
            body_len = 4'd0;
          end
        end
      endcase
    end
  end

  // join prefix and body
  assign text     = {pre_word, {(TEXT_W-24){1'b0}}} | (body >> {pre_len, 3'b000});
  assign text_len = {2'b00, pre_len} + body_len;

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start      <= 1'b1;
      pending_bytes <= 16'b0;
      pending_count <= 2'd0;
    end else if (in_xfer) begin
      if (ends) begin
        at_start      <= 1'b1;
        pending_bytes <= 16'b0;
        pending_count <= 2'd0;
      end else begin
        at_start <= 1'b0;
        if (mode_eff == MODE_B64) begin
          priority if (pending_count == 2'd2) begin
            pending_bytes <= 16'b0;
            pending_count <= 2'd0;
          end else if (pending_count == 2'd0) begin
            pending_bytes <= {data_byte, 8'b0};
            pending_count <= 2'd1;
          end else begin
            pending_bytes[7:0] <= data_byte;
            pending_count      <= 2'd2;
          end
        end
      end
    end
  end

  // result buffer, shifts one character out per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_left <= 4'd0;
    end else if (in_xfer && text_len != 4'd0) begin
      buf_left <= text_len;
    end else if (out_xfer) begin
      buf_left <= buf_left - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && text_len != 4'd0) begin
      buf_chars <= text;
      buf_ends  <= ends;
    end else if (out_xfer) begin
      buf_chars <= buf_chars << 8;
    end
  end

  // checks
  `BSTE_ASSERT_NOW(a_pending_range, 1'b1, pending_count != 2'd3)
  `BSTE_ASSERT_NOW(a_buf_range, out_valid, buf_left <= 4'd12)
  `BSTE_ASSERT_NEXT(a_run_continues, out_xfer && !run_last, out_valid)
  `BSTE_ASSERT_NEXT(a_end_restarts, in_xfer && ends, at_start && pending_count == 2'd0)

endmodule
